@@ rtl/core/tun_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;

    localparam int N_AXES = 3;

    typedef struct packed {
        logic              valid;
        logic              degen;
        logic [N_AXES-1:0] neg;
    } t_ctl;

endpackage
`default_nettype wire

@@ rtl/core/tun_root_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One bit of the normalising search for every axis: tries q + 2^K against
// (2q-1)^2 * S <= 4 * c^2 * 2^(2F), kept as running residual R and P = (2q-1)*S.
module tun_root_step #(
    parameter int RW = 110,
    parameter int QW = 15,
    parameter int K  = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire tun_pkg::t_ctl           i_ctl,
    input  wire logic signed [RW-1:0]    i_s,
    input  wire logic signed [RW-1:0]    i_r [tun_pkg::N_AXES],
    input  wire logic signed [RW-1:0]    i_p [tun_pkg::N_AXES],
    input  wire logic        [QW-1:0]    i_q [tun_pkg::N_AXES],
    output tun_pkg::t_ctl                o_ctl,
    output logic signed [RW-1:0]         o_s,
    output logic signed [RW-1:0]         o_r [tun_pkg::N_AXES],
    output logic signed [RW-1:0]         o_p [tun_pkg::N_AXES],
    output logic        [QW-1:0]         o_q [tun_pkg::N_AXES]
);

    tun_pkg::t_ctl          r_ctl;
    logic signed [RW-1:0]   r_s;
    logic signed [RW-1:0]   r_r [tun_pkg::N_AXES];
    logic signed [RW-1:0]   r_p [tun_pkg::N_AXES];
    logic        [QW-1:0]   r_q [tun_pkg::N_AXES];
    logic signed [RW-1:0]   n_diff [tun_pkg::N_AXES];
    logic signed [RW-1:0]   n_r [tun_pkg::N_AXES];
    logic signed [RW-1:0]   n_p [tun_pkg::N_AXES];
    logic        [QW-1:0]   n_q [tun_pkg::N_AXES];

    always_comb begin
        for (int i = 0; i < tun_pkg::N_AXES; i++) begin
            n_diff[i] = i_r[i] - (i_p[i] <<< (K + 2)) - (i_s <<< (2 * K + 2));
            if (!n_diff[i][RW-1]) begin
                n_r[i] = n_diff[i];
                n_p[i] = i_p[i] + (i_s <<< (K + 1));
                n_q[i] = i_q[i] | (QW'(1) << K);
            end else begin
                n_r[i] = i_r[i];
                n_p[i] = i_p[i];
                n_q[i] = i_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= i_s;
            r_r <= n_r;
            r_p <= n_p;
            r_q <= n_q;
        end
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_r   = r_r;
    assign o_p   = r_p;
    assign o_q   = r_q;

endmodule
`default_nettype wire

@@ rtl/core/triangle_unit_normal.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Unit face normal of a triangle.
// Input channel: nine signed vertex coordinates with i_valid / o_stall; an
// item is taken on a rising edge with i_valid high and o_stall low.
// Output channel: three signed Q1.F normal components and a degenerate flag
// with o_valid / i_stall; the flag is set, and the components are zero, when
// the cross product of edge vectors a-b and b-c is the zero vector.
// Throughput: one item per cycle while no result waits under i_stall.
// Pipeline: edges, products, cross terms, split squares, squares, square
// sum, search set-up, one stage per result bit of the normalising search,
// output register.
// Stall: the whole pipeline holds while a result waits under i_stall, and
// o_stall is raised for as long; no item is dropped or repeated.
// Reset: synchronous, active low, clears every valid bit; no item is in
// flight afterwards.
module triangle_unit_normal #(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [COORD_BITS-1:0]       i_vertex_a_x,
    input  wire logic signed [COORD_BITS-1:0]       i_vertex_a_y,
    input  wire logic signed [COORD_BITS-1:0]       i_vertex_a_z,
    input  wire logic signed [COORD_BITS-1:0]       i_vertex_b_x,
    input  wire logic signed [COORD_BITS-1:0]       i_vertex_b_y,
    input  wire logic signed [COORD_BITS-1:0]       i_vertex_b_z,
    input  wire logic signed [COORD_BITS-1:0]       i_vertex_c_x,
    input  wire logic signed [COORD_BITS-1:0]       i_vertex_c_y,
    input  wire logic signed [COORD_BITS-1:0]       i_vertex_c_z,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [NORMAL_FRAC_BITS+1:0]      o_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0]      o_normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0]      o_normal_z,
    output logic                                    o_degenerate
);

    localparam int N   = tun_pkg::N_AXES;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int EW  = COORD_BITS + 1;
    localparam int PW  = 2 * COORD_BITS + 1;
    localparam int CW  = 2 * COORD_BITS + 2;
    localparam int MW  = 2 * COORD_BITS + 1;
    localparam int LW  = (MW + 1) / 2;
    localparam int HW  = MW - LW;
    localparam int SW  = 2 * MW;
    localparam int SSW = SW + 2;
    localparam int RW  = SW + 2 * F + 8;
    localparam int QW  = F + 1;
    localparam int OW  = F + 2;

    logic en;

    logic                   r_v1, r_v2;
    tun_pkg::t_ctl          r_c3, r_c4, r_c5, r_c6, r_c7;
    logic                   r_out_valid;

    logic signed [EW-1:0]   r_ea [N];
    logic signed [EW-1:0]   r_eb [N];
    logic signed [PW-1:0]   r_p1 [N];
    logic signed [PW-1:0]   r_p2 [N];
    logic        [MW-1:0]   r_mag [N];
    logic        [2*HW-1:0] r_hh [N];
    logic        [MW-1:0]   r_hl [N];
    logic        [2*LW-1:0] r_ll [N];
    logic        [SW-1:0]   r_sq [N];
    logic        [SW-1:0]   r_sq6 [N];
    logic        [SSW-1:0]  r_s6;
    logic signed [RW-1:0]   r_s7;
    logic signed [RW-1:0]   r_r7 [N];
    logic signed [RW-1:0]   r_p7 [N];
    logic        [QW-1:0]   r_q7 [N];
    logic signed [OW-1:0]   r_nrm [N];
    logic                   r_deg;

    logic signed [PW-1:0]   n_ea [N];
    logic signed [PW-1:0]   n_eb [N];
    logic signed [CW-1:0]   n_cross [N];
    logic        [N-1:0]    n_neg;
    logic        [MW-1:0]   n_mag [N];
    logic        [HW-1:0]   n_hi [N];
    logic        [LW-1:0]   n_lo [N];
    logic signed [OW-1:0]   n_qx [N];

    tun_pkg::t_ctl          w_ctl [QW+1];
    logic signed [RW-1:0]   w_s [QW+1];
    logic signed [RW-1:0]   w_r [QW+1][N];
    logic signed [RW-1:0]   w_p [QW+1][N];
    logic        [QW-1:0]   w_q [QW+1][N];

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_ea[i] = PW'(r_ea[i]);
            n_eb[i] = PW'(r_eb[i]);
        end
        for (int i = 0; i < N; i++) begin
            n_cross[i] = CW'(r_p1[i]) - CW'(r_p2[i]);
            n_neg[i]   = n_cross[i][CW-1];
            n_mag[i]   = n_neg[i] ? MW'(-n_cross[i]) : MW'(n_cross[i]);
            n_hi[i]    = r_mag[i][MW-1:LW];
            n_lo[i]    = r_mag[i][LW-1:0];
            n_qx[i]    = OW'(w_q[QW][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_c3        <= '0;
            r_c4        <= '0;
            r_c5        <= '0;
            r_c6        <= '0;
            r_c7        <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_c3        <= '{valid: r_v2, degen: 1'b0, neg: n_neg};
            r_c4        <= r_c3;
            r_c5        <= r_c4;
            r_c6        <= r_c5;
            r_c7        <= '{valid: r_c6.valid, degen: (r_s6 == '0), neg: r_c6.neg};
            r_out_valid <= w_ctl[QW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ea[0] <= EW'(i_vertex_a_x) - EW'(i_vertex_b_x);
            r_ea[1] <= EW'(i_vertex_a_y) - EW'(i_vertex_b_y);
            r_ea[2] <= EW'(i_vertex_a_z) - EW'(i_vertex_b_z);
            r_eb[0] <= EW'(i_vertex_b_x) - EW'(i_vertex_c_x);
            r_eb[1] <= EW'(i_vertex_b_y) - EW'(i_vertex_c_y);
            r_eb[2] <= EW'(i_vertex_b_z) - EW'(i_vertex_c_z);

            r_p1[0] <= n_ea[1] * n_eb[2];
            r_p2[0] <= n_ea[2] * n_eb[1];
            r_p1[1] <= n_ea[2] * n_eb[0];
            r_p2[1] <= n_ea[0] * n_eb[2];
            r_p1[2] <= n_ea[0] * n_eb[1];
            r_p2[2] <= n_ea[1] * n_eb[0];

            for (int i = 0; i < N; i++) begin
                r_mag[i] <= n_mag[i];
                r_hh[i]  <= (2*HW)'(n_hi[i]) * (2*HW)'(n_hi[i]);
                r_hl[i]  <= MW'(n_hi[i]) * MW'(n_lo[i]);
                r_ll[i]  <= (2*LW)'(n_lo[i]) * (2*LW)'(n_lo[i]);
                r_sq[i]  <= (SW'(r_hh[i]) << (2 * LW)) + (SW'(r_hl[i]) << (LW + 1))
                            + SW'(r_ll[i]);
                r_sq6[i] <= r_sq[i];
                r_r7[i]  <= (RW'(r_sq6[i]) <<< (2 * F + 2)) - RW'(r_s6);
                r_p7[i]  <= -RW'(r_s6);
                r_q7[i]  <= '0;
            end
            r_s6 <= SSW'(r_sq[0]) + SSW'(r_sq[1]) + SSW'(r_sq[2]);
            r_s7 <= RW'(r_s6);

            for (int i = 0; i < N; i++) begin
                if (w_ctl[QW].degen) begin
                    r_nrm[i] <= '0;
                end else if (w_ctl[QW].neg[i]) begin
                    r_nrm[i] <= -n_qx[i];
                end else begin
                    r_nrm[i] <= n_qx[i];
                end
            end
            r_deg <= w_ctl[QW].degen;
        end
    end

    assign w_ctl[0] = r_c7;
    assign w_s[0]   = r_s7;
    assign w_r[0]   = r_r7;
    assign w_p[0]   = r_p7;
    assign w_q[0]   = r_q7;

    for (genvar g = 0; g < QW; g++) begin : g_step
        tun_root_step #(
            .RW (RW),
            .QW (QW),
            .K  (F - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (w_ctl[g]),
            .i_s     (w_s[g]),
            .i_r     (w_r[g]),
            .i_p     (w_p[g]),
            .i_q     (w_q[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_s     (w_s[g+1]),
            .o_r     (w_r[g+1]),
            .o_p     (w_p[g+1]),
            .o_q     (w_q[g+1])
        );
    end

    assign o_valid      = r_out_valid;
    assign o_normal_x   = r_nrm[0];
    assign o_normal_y   = r_nrm[1];
    assign o_normal_z   = r_nrm[2];
    assign o_degenerate = r_deg;

endmodule
`default_nettype wire

@@ rtl/core/tun_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tun_checker #(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic signed [NORMAL_FRAC_BITS+1:0] o_normal_x,
    input wire logic signed [NORMAL_FRAC_BITS+1:0] o_normal_y,
    input wire logic signed [NORMAL_FRAC_BITS+1:0] o_normal_z,
    input wire logic                               o_degenerate
);

    localparam logic signed [NORMAL_FRAC_BITS+1:0] ONE =
        (NORMAL_FRAC_BITS+2)'(1) << NORMAL_FRAC_BITS;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0)
        else $error("degenerate item with non-zero normal");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |-> o_normal_x != '0 || o_normal_y != '0 || o_normal_z != '0)
        else $error("zero normal without degenerate flag");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normal_x <= ONE && o_normal_x >= -ONE && o_normal_y <= ONE
                    && o_normal_y >= -ONE && o_normal_z <= ONE && o_normal_z >= -ONE)
        else $error("normal component outside unit range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_normal_x) && $stable(o_normal_y)
                               && $stable(o_normal_z) && $stable(o_degenerate))
        else $error("stalled item changed");

endmodule

bind triangle_unit_normal tun_checker #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tun_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_normal_x   (o_normal_x),
    .o_normal_y   (o_normal_y),
    .o_normal_z   (o_normal_z),
    .o_degenerate (o_degenerate)
);
`default_nettype wire
